/* rtl/pidtf_pkg.sv */
package pidtf_pkg;

  // Fixed-point formats
  localparam int FRAC_BITS = 12;
  localparam int COEF_BITS = 12;

  // Field widths
  localparam int IN_W       = 24;
  localparam int ERR_W      = IN_W + 1;
  localparam int GAIN_W     = 23;
  localparam int COEF_W     = 13;
  localparam int HIGH_W     = 31;
  localparam int ISUM_W     = 32;
  localparam int DRIVE_W    = 13;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  // Shared multiplier: signed operand by zero-extended gain or coefficient
  localparam int MUL_A_W = ISUM_W + 1;
  localparam int MUL_B_W = GAIN_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = PROD_W - FRAC_BITS + 3;
  localparam int FILT_W  = PROD_W + 1;

  localparam int DRV_RSH = (FRAC_BITS >= COEF_BITS) ? (FRAC_BITS - COEF_BITS) : 0;
  localparam int DRV_LSH = (FRAC_BITS >= COEF_BITS) ? 0 : (COEF_BITS - FRAC_BITS);

  typedef struct packed {
    logic signed [IN_W-1:0] target;
    logic signed [IN_W-1:0] measured;
  } in_t;

  typedef struct packed {
    logic [DRIVE_W-1:0] drive;
    logic               clamped;
  } out_t;

  typedef struct packed {
    logic                     mode;
    logic [GAIN_W-1:0]        p_gain;
    logic [GAIN_W-1:0]        i_gain;
    logic [GAIN_W-1:0]        deriv_gain;
    logic [HIGH_W-1:0]        integral_high;
    logic signed [ISUM_W-1:0] integral_low;
    logic [COEF_W-1:0]        setpoint_weight;
    logic [COEF_W-1:0]        deriv_pole;
  } cfg_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE            = 3'd0,
    REG_P_GAIN          = 3'd1,
    REG_I_GAIN          = 3'd2,
    REG_DERIV_GAIN      = 3'd3,
    REG_INTEGRAL_HIGH   = 3'd4,
    REG_INTEGRAL_LOW    = 3'd5,
    REG_SETPOINT_WEIGHT = 3'd6,
    REG_DERIV_POLE      = 3'd7
  } cfg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_INTEG,
    ST_MUL_I,
    ST_ACC_I,
    ST_MUL_P0,
    ST_ACC_P0,
    ST_MUL_D0,
    ST_ACC_D0,
    ST_MUL_WS,
    ST_ACC_WS,
    ST_MUL_P1,
    ST_ACC_P1,
    ST_MUL_F,
    ST_ACC_F,
    ST_MUL_G,
    ST_ACC_G,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    MS_I,
    MS_P0,
    MS_D0,
    MS_WS,
    MS_P1,
    MS_F,
    MS_G
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_ADD,
    ACT_ADD_D0,
    ACT_AUX,
    ACT_FILT
  } act_t;

  typedef struct packed {
    logic     load;
    logic     integ;
    logic     mul_en;
    mul_sel_t mul_sel;
    act_t     act;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic out_busy;
  } sts_t;

endpackage

/* rtl/pidtf_ctrl.sv */
module pidtf_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  pidtf_pkg::sts_t  sts,
  output pidtf_pkg::cmd_t  cmd
);

  pidtf_pkg::state_t state_r;
  pidtf_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pidtf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pidtf_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = pidtf_pkg::ST_INTEG;
      end
      pidtf_pkg::ST_INTEG:   state_nxt = pidtf_pkg::ST_MUL_I;
      pidtf_pkg::ST_MUL_I:   state_nxt = pidtf_pkg::ST_ACC_I;
      pidtf_pkg::ST_ACC_I: begin
        state_nxt = sts.mode ? pidtf_pkg::ST_MUL_WS : pidtf_pkg::ST_MUL_P0;
      end
      pidtf_pkg::ST_MUL_P0:  state_nxt = pidtf_pkg::ST_ACC_P0;
      pidtf_pkg::ST_ACC_P0:  state_nxt = pidtf_pkg::ST_MUL_D0;
      pidtf_pkg::ST_MUL_D0:  state_nxt = pidtf_pkg::ST_ACC_D0;
      pidtf_pkg::ST_ACC_D0:  state_nxt = pidtf_pkg::ST_EMIT;
      pidtf_pkg::ST_MUL_WS:  state_nxt = pidtf_pkg::ST_ACC_WS;
      pidtf_pkg::ST_ACC_WS:  state_nxt = pidtf_pkg::ST_MUL_P1;
      pidtf_pkg::ST_MUL_P1:  state_nxt = pidtf_pkg::ST_ACC_P1;
      pidtf_pkg::ST_ACC_P1:  state_nxt = pidtf_pkg::ST_MUL_F;
      pidtf_pkg::ST_MUL_F:   state_nxt = pidtf_pkg::ST_ACC_F;
      pidtf_pkg::ST_ACC_F:   state_nxt = pidtf_pkg::ST_MUL_G;
      pidtf_pkg::ST_MUL_G:   state_nxt = pidtf_pkg::ST_ACC_G;
      pidtf_pkg::ST_ACC_G:   state_nxt = pidtf_pkg::ST_EMIT;
      pidtf_pkg::ST_EMIT: begin
        if (!sts.out_busy) state_nxt = pidtf_pkg::ST_IDLE;
      end
      default:               state_nxt = pidtf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.mul_sel = pidtf_pkg::MS_I;
    cmd.act     = pidtf_pkg::ACT_NONE;
    in_stall    = (state_r != pidtf_pkg::ST_IDLE);
    unique case (state_r)
      pidtf_pkg::ST_IDLE:   cmd.load = in_valid;
      pidtf_pkg::ST_INTEG:  cmd.integ = 1'b1;
      pidtf_pkg::ST_MUL_I: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = pidtf_pkg::MS_I;
      end
      pidtf_pkg::ST_MUL_P0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = pidtf_pkg::MS_P0;
      end
      pidtf_pkg::ST_MUL_D0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = pidtf_pkg::MS_D0;
      end
      pidtf_pkg::ST_MUL_WS: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = pidtf_pkg::MS_WS;
      end
      pidtf_pkg::ST_MUL_P1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = pidtf_pkg::MS_P1;
      end
      pidtf_pkg::ST_MUL_F: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = pidtf_pkg::MS_F;
      end
      pidtf_pkg::ST_MUL_G: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = pidtf_pkg::MS_G;
      end
      pidtf_pkg::ST_ACC_I,
      pidtf_pkg::ST_ACC_P0,
      pidtf_pkg::ST_ACC_P1: cmd.act = pidtf_pkg::ACT_ADD;
      pidtf_pkg::ST_ACC_D0: cmd.act = pidtf_pkg::ACT_ADD_D0;
      pidtf_pkg::ST_ACC_WS,
      pidtf_pkg::ST_ACC_F:  cmd.act = pidtf_pkg::ACT_AUX;
      pidtf_pkg::ST_ACC_G:  cmd.act = pidtf_pkg::ACT_FILT;
      pidtf_pkg::ST_EMIT:   cmd.emit = !sts.out_busy;
      default:              cmd = '0;
    endcase
  end

  a_accept_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("accepted beat did not start a tick");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !sts.out_busy)
    else $error("result written over a stalled beat");

  a_idle_is_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> (!cmd.mul_en && cmd.act == pidtf_pkg::ACT_NONE && !cmd.emit && !cmd.integ))
    else $error("datapath command issued while idle");

endmodule

/* rtl/pidtf_dp.sv */
module pidtf_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  pidtf_pkg::in_t   in_data,
  input  pidtf_pkg::cfg_t  cfg,
  input  pidtf_pkg::cmd_t  cmd,
  output pidtf_pkg::sts_t  sts,
  output logic             out_valid,
  input  logic             out_stall,
  output pidtf_pkg::out_t  out_data
);

  localparam int MA = pidtf_pkg::MUL_A_W;
  localparam int MB = pidtf_pkg::MUL_B_W;
  localparam int PW = pidtf_pkg::PROD_W;
  localparam int AW = pidtf_pkg::ACC_W;
  localparam int FW = pidtf_pkg::FILT_W;
  localparam int IW = pidtf_pkg::ISUM_W;
  localparam int EW = pidtf_pkg::ERR_W;
  localparam int NW = pidtf_pkg::IN_W;
  localparam int DW = pidtf_pkg::DRIVE_W;

  // Payload
  logic signed [NW-1:0] tgt_r, tgt_nxt;
  logic signed [NW-1:0] meas_r, meas_nxt;
  logic signed [EW-1:0] err_r, err_nxt;
  logic signed [PW-1:0] prod_r, prod_nxt;
  logic signed [MA-1:0] aux_r, aux_nxt;
  logic signed [AW-1:0] acc_r, acc_nxt;
  pidtf_pkg::out_t      out_data_r, out_data_nxt;

  // Controller state kept across ticks
  logic signed [IW-1:0] isum_r, isum_nxt;
  logic signed [IW-1:0] dm_r, dm_nxt;
  logic signed [NW-1:0] last_r, last_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic signed [MA-1:0] mul_a;
  logic signed [MB-1:0] mul_b;
  logic signed [PW-1:0] prod_f;
  logic signed [PW-1:0] prod_c;
  logic signed [IW:0]   isum_raw;
  logic signed [IW:0]   isum_hi;
  logic signed [IW:0]   high_ext;
  logic signed [IW:0]   low_ext;
  logic signed [FW-1:0] filt;
  logic signed [IW-1:0] filt_sat;
  logic signed [AW-1:0] one_val;
  logic [AW-1:0]        sum_clip;
  logic [AW-1:0]        drive_full;
  logic                 clip_flag;

  assign sts.mode     = cfg.mode;
  assign sts.out_busy = out_valid_r && out_stall;
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

  // Operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mul_sel)
      pidtf_pkg::MS_I: begin
        mul_a = MA'(isum_r);
        mul_b = signed'(MB'(cfg.i_gain));
      end
      pidtf_pkg::MS_P0: begin
        mul_a = MA'(err_r);
        mul_b = signed'(MB'(cfg.p_gain));
      end
      pidtf_pkg::MS_D0: begin
        mul_a = MA'(err_r) - MA'(dm_r);
        mul_b = signed'(MB'(cfg.deriv_gain));
      end
      pidtf_pkg::MS_WS: begin
        mul_a = MA'(tgt_r);
        mul_b = signed'(MB'(cfg.setpoint_weight));
      end
      pidtf_pkg::MS_P1: begin
        mul_a = aux_r - MA'(meas_r);
        mul_b = signed'(MB'(cfg.p_gain));
      end
      pidtf_pkg::MS_F: begin
        mul_a = MA'(dm_r);
        mul_b = signed'(MB'(cfg.deriv_pole));
      end
      pidtf_pkg::MS_G: begin
        mul_a = MA'(meas_r) - MA'(last_r);
        mul_b = signed'(MB'(cfg.deriv_gain));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_f = prod_r >>> pidtf_pkg::FRAC_BITS;
  assign prod_c = prod_r >>> pidtf_pkg::COEF_BITS;

  // Integral update: upper limit first, lower limit wins when they cross
  assign high_ext = signed'((IW + 1)'(cfg.integral_high));
  assign low_ext  = (IW + 1)'(cfg.integral_low);
  assign isum_raw = (IW + 1)'(isum_r) + (IW + 1)'(err_r);
  assign isum_hi  = (isum_raw > high_ext) ? high_ext : isum_raw;

  // Filtered derivative, saturated to the state width
  always_comb begin
    filt = FW'(aux_r) - FW'(prod_f);
    if (filt > FW'(signed'({1'b0, {(IW - 1){1'b1}}}))) begin
      filt_sat = {1'b0, {(IW - 1){1'b1}}};
    end else if (filt < FW'(signed'({1'b1, {(IW - 1){1'b0}}}))) begin
      filt_sat = {1'b1, {(IW - 1){1'b0}}};
    end else begin
      filt_sat = IW'(filt);
    end
  end

  // Output clamp to 0..1 and format change
  always_comb begin
    one_val   = AW'(1) <<< pidtf_pkg::FRAC_BITS;
    sum_clip  = unsigned'(acc_r);
    clip_flag = 1'b0;
    priority if (acc_r > one_val) begin
      sum_clip  = unsigned'(one_val);
      clip_flag = 1'b1;
    end else if (acc_r < 0) begin
      sum_clip  = '0;
      clip_flag = 1'b1;
    end else begin
      sum_clip  = unsigned'(acc_r);
      clip_flag = 1'b0;
    end
    drive_full = (sum_clip >> pidtf_pkg::DRV_RSH) << pidtf_pkg::DRV_LSH;
  end

  always_comb begin
    tgt_nxt       = tgt_r;
    meas_nxt      = meas_r;
    err_nxt       = err_r;
    prod_nxt      = prod_r;
    aux_nxt       = aux_r;
    acc_nxt       = acc_r;
    isum_nxt      = isum_r;
    dm_nxt        = dm_r;
    last_nxt      = last_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;

    if (cmd.load) begin
      tgt_nxt  = in_data.target;
      meas_nxt = in_data.measured;
      err_nxt  = EW'(in_data.target) - EW'(in_data.measured);
      acc_nxt  = '0;
    end

    if (cmd.integ) begin
      isum_nxt = IW'((isum_hi < low_ext) ? low_ext : isum_hi);
    end

    if (cmd.mul_en) begin
      prod_nxt = mul_a * mul_b;
    end

    unique case (cmd.act)
      pidtf_pkg::ACT_NONE: ;
      pidtf_pkg::ACT_ADD:  acc_nxt = acc_r + AW'(prod_f);
      pidtf_pkg::ACT_ADD_D0: begin
        acc_nxt = acc_r + AW'(prod_f);
        dm_nxt  = IW'(err_r);
      end
      pidtf_pkg::ACT_AUX:  aux_nxt = MA'(prod_c);
      pidtf_pkg::ACT_FILT: begin
        dm_nxt   = filt_sat;
        acc_nxt  = acc_r + AW'(filt_sat);
        last_nxt = meas_r;
      end
      default: ;
    endcase

    if (cmd.emit) begin
      out_data_nxt.drive   = drive_full[DW-1:0];
      out_data_nxt.clamped = clip_flag;
      out_valid_nxt        = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    tgt_r      <= tgt_nxt;
    meas_r     <= meas_nxt;
    err_r      <= err_nxt;
    prod_r     <= prod_nxt;
    aux_r      <= aux_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      isum_r      <= '0;
      dm_r        <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      isum_r      <= isum_nxt;
      dm_r        <= dm_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_isum_in_limits: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.integ && (cfg.integral_low <= signed'(IW'(cfg.integral_high))))
    |=> ((isum_r >= $past(cfg.integral_low)) &&
         (isum_r <= signed'(IW'($past(cfg.integral_high))))))
    else $error("integral sum outside its limits");

  a_drive_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.drive <= (DW'(1) << pidtf_pkg::COEF_BITS)))
    else $error("drive above full scale");

  a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> $past(cmd.emit))
    else $error("result beat appeared without a tick finishing");

endmodule

/* rtl/pid_controller_two_forms.sv */
// PID controller, one tick per input beat, plain or setpoint-weighted form.
//
// Input channel (in_valid / in_stall / in_data): a beat carries target and
// measured, signed Q12.12. A beat is taken when in_valid is high and in_stall
// is low. Output channel (out_valid / out_stall / out_data): one beat per
// tick with drive (Q1.12, 0..1) and the clamped flag.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): cfg_ready is
// always high; write registers only while no tick is in flight.
//
// One tick is in work at a time, so no new beat is accepted until the current
// tick has finished. The work runs on the single shared 33x24 multiplier with
// its output register: three products in mode 0, five in mode 1, each taking
// a multiply state and an accumulate state.
// A finished result waits in the output register; the next beat is accepted
// while it is stalled, and that tick holds in its last step until the
// output register is free.
// Reset (rst_n low, synchronous) clears the integral sum, derivative memory
// and last measurement, and loads the register defaults.
module pid_controller_two_forms (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  pidtf_pkg::in_t                   in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output pidtf_pkg::out_t                  out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pidtf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pidtf_pkg::CFG_DATA_W-1:0] cfg_data
);

  pidtf_pkg::cfg_t cfg_r, cfg_nxt;
  pidtf_pkg::cmd_t cmd;
  pidtf_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (pidtf_pkg::cfg_idx_t'(cfg_index))
        pidtf_pkg::REG_MODE:            cfg_nxt.mode = cfg_data[0];
        pidtf_pkg::REG_P_GAIN:          cfg_nxt.p_gain = cfg_data[pidtf_pkg::GAIN_W-1:0];
        pidtf_pkg::REG_I_GAIN:          cfg_nxt.i_gain = cfg_data[pidtf_pkg::GAIN_W-1:0];
        pidtf_pkg::REG_DERIV_GAIN:      cfg_nxt.deriv_gain = cfg_data[pidtf_pkg::GAIN_W-1:0];
        pidtf_pkg::REG_INTEGRAL_HIGH: begin
          cfg_nxt.integral_high = cfg_data[pidtf_pkg::HIGH_W-1:0];
        end
        pidtf_pkg::REG_INTEGRAL_LOW: begin
          cfg_nxt.integral_low = signed'(cfg_data[pidtf_pkg::ISUM_W-1:0]);
        end
        pidtf_pkg::REG_SETPOINT_WEIGHT: begin
          cfg_nxt.setpoint_weight = cfg_data[pidtf_pkg::COEF_W-1:0];
        end
        pidtf_pkg::REG_DERIV_POLE: begin
          cfg_nxt.deriv_pole = cfg_data[pidtf_pkg::COEF_W-1:0];
        end
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode            <= 1'b0;
      cfg_r.p_gain          <= pidtf_pkg::GAIN_W'(1 << pidtf_pkg::FRAC_BITS);
      cfg_r.i_gain          <= '0;
      cfg_r.deriv_gain      <= '0;
      cfg_r.integral_high   <= '1;
      cfg_r.integral_low    <= {1'b1, {(pidtf_pkg::ISUM_W - 1){1'b0}}};
      cfg_r.setpoint_weight <= pidtf_pkg::COEF_W'(1 << pidtf_pkg::COEF_BITS);
      cfg_r.deriv_pole      <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  pidtf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  pidtf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg       (cfg_r),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
